// ===== sv/gvn_pkg.sv =====
// Shared constants and types for the grid vertex normal sum block.
package gvn_pkg;

	// Store depth, a power of two
	localparam int MAX_TRIANGLES = 2048;
	localparam int ADDR_W        = $clog2(MAX_TRIANGLES);
	localparam int CELL_W        = ADDR_W - 1;
	localparam int COORD_W       = 11;
	localparam int NORM_W        = 16;
	localparam int ENTRY_W       = 3 * NORM_W;
	localparam int PROD_W        = 2 * COORD_W;
	localparam int STEP_W        = 3;
	localparam int CFG_IDX_W     = 1;

	// Request opcodes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELLS_WIDE = 1'b0,
		REG_CELLS_HIGH = 1'b1
	} cfg_reg_t;

	// Reset values of the configuration registers
	localparam logic [COORD_W-1:0] CELLS_WIDE_RST = COORD_W'(1);
	localparam logic [COORD_W-1:0] CELLS_HIGH_RST = COORD_W'(0);

	// Neighbor cells, walked in this order
	typedef enum logic [1:0] {
		NB_UPLEFT = 2'd0,
		NB_LEFT   = 2'd1,
		NB_UP     = 2'd2,
		NB_OWN    = 2'd3
	} nb_cell_t;

	// Query sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_UP,
		ST_MUL_OWN,
		ST_READ,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Store write port
	typedef struct packed {
		logic               en;
		logic [ADDR_W-1:0]  addr;
		logic [ENTRY_W-1:0] data;
	} store_wr_t;

	// Store read port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} store_rd_t;

endpackage

// ===== sv/gvn_if.sv =====
// Handshake channels of the grid vertex normal sum block.
interface gvn_cmd_if;
	import gvn_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      command;
	logic [COORD_W-1:0]        triangle_slot;
	logic signed [NORM_W-1:0]  normal_x;
	logic signed [NORM_W-1:0]  normal_y;
	logic signed [NORM_W-1:0]  normal_z;
	logic [COORD_W-1:0]        vertex_x;
	logic [COORD_W-1:0]        vertex_y;

	modport source (output valid, command, triangle_slot, normal_x, normal_y, normal_z,
		vertex_x, vertex_y, input ready);
	modport sink (input valid, command, triangle_slot, normal_x, normal_y, normal_z,
		vertex_x, vertex_y, output ready);
endinterface

interface gvn_rsp_if;
	import gvn_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [NORM_W-1:0]  sum_x;
	logic signed [NORM_W-1:0]  sum_y;
	logic signed [NORM_W-1:0]  sum_z;

	modport source (output valid, sum_x, sum_y, sum_z, input ready);
	modport sink (input valid, sum_x, sum_y, sum_z, output ready);
endinterface

interface gvn_cfg_if;
	import gvn_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COORD_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/gvn_store.sv =====
// Normal store: one write port and one read port with registered read data.
module gvn_store (
	input  logic                        clk,
	input  gvn_pkg::store_wr_t          wr,
	input  gvn_pkg::store_rd_t          rd,
	output logic [gvn_pkg::ENTRY_W-1:0] rd_data
);
	import gvn_pkg::*;

	logic [ENTRY_W-1:0] mem [MAX_TRIANGLES];
	logic [ENTRY_W-1:0] rd_data_q;

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read one entry into the output register
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ===== sv/grid_vertex_normal_sum.sv =====
// Top level of the grid vertex normal sum block: sequencer, accumulator, registers.
//
// Requests arrive on cmd. A write request (command 0) stores one face normal
// at triangle_slot and gives no response. A query request (command 1) names
// vertex (vertex_x, vertex_y) and gives one response on rsp holding the
// wrapped sums of the normals of the adjacent triangles.
// A query runs through one shared multiplier (the base of the upper row and
// of the own row), then eight store read slots on the single read port, one
// per candidate triangle, then a drain step and a load step. cmd is ready
// again from the cycle in which the response turns valid, and it takes no
// request while a query is in flight.
// The response sits in an output register; a stalled rsp holds it, and cmd
// keeps taking write requests and a next query meanwhile. A query that ends
// while the previous response still waits holds in its last state.
// cfg writes cells_wide (index 0) and cells_high (index 1) and is always ready.
// Users write it only while no query is in flight; the block does not enforce it.
// Reset clears the sequencer and the response valid and sets cells_wide to 1
// and cells_high to 0. The normal store is not cleared: every entry must be
// written before a query reads it.
module grid_vertex_normal_sum (
	input  logic clk,
	input  logic arst_n,
	gvn_cmd_if.sink   cmd,
	gvn_rsp_if.source rsp,
	gvn_cfg_if.sink   cfg
);
	import gvn_pkg::*;

	state_t state_q, state_d;

	logic [COORD_W-1:0] cells_wide_q, cells_high_q;
	logic [COORD_W-1:0] x_q;
	logic               even_q, xpos_q, ypos_q, xinw_q, yinh_q;
	logic [COORD_W-1:0] ymul_q;
	logic [CELL_W-1:0]  row_up_q, row_own_q;
	logic [STEP_W-1:0]  step_q;
	logic               take_s1;
	logic [NORM_W-1:0]  acc_x_q, acc_y_q, acc_z_q;
	logic               rsp_valid_q;
	logic [NORM_W-1:0]  rsp_x_q, rsp_y_q, rsp_z_q;

	logic               cmd_acc, cfg_acc, rsp_acc;
	logic               start_qry, load_rsp;
	logic [PROD_W-1:0]  prod;
	nb_cell_t           nb;
	logic               slot;
	logic               take;
	logic [CELL_W-1:0]  row_sel, col_sel, cell_idx;
	logic [ENTRY_W-1:0] rd_data;
	store_wr_t          st_wr;
	store_rd_t          st_rd;

	assign cmd_acc   = cmd.valid & cmd.ready;
	assign cfg_acc   = cfg.valid & cfg.ready;
	assign rsp_acc   = rsp_valid_q & rsp.ready;
	assign start_qry = cmd_acc & (cmd.command == CMD_QUERY);
	assign cfg.ready = 1'b1;

	// Shared multiplier: row index times grid width
	assign prod = PROD_W'(ymul_q) * PROD_W'(cells_wide_q);

	// Decode the current read slot into neighbor cell and triangle
	assign nb   = nb_cell_t'(step_q[STEP_W-1:1]);
	assign slot = step_q[0];

	always_comb begin
		take    = 1'b0;
		row_sel = row_own_q;
		col_sel = CELL_W'(x_q);
		case (nb)
			NB_UPLEFT: begin
				take    = xpos_q & ypos_q & (slot | even_q);
				row_sel = row_up_q;
				col_sel = CELL_W'(x_q - COORD_W'(1));
			end
			NB_LEFT: begin
				take    = xpos_q & yinh_q & (slot | even_q);
				col_sel = CELL_W'(x_q - COORD_W'(1));
			end
			NB_UP: begin
				take    = xinw_q & ypos_q & (~slot | ~even_q);
				row_sel = row_up_q;
			end
			NB_OWN: begin
				take    = xinw_q & yinh_q & (~slot | ~even_q);
			end
			default: begin
				take    = 1'b0;
			end
		endcase
	end

	assign cell_idx = row_sel + col_sel;

	// Store ports
	always_comb begin
		st_wr.en   = cmd_acc & (cmd.command == CMD_WRITE);
		st_wr.addr = ADDR_W'(cmd.triangle_slot);
		st_wr.data = {cmd.normal_x, cmd.normal_y, cmd.normal_z};
		st_rd.en   = (state_q == ST_READ) & take;
		st_rd.addr = {cell_idx, slot};
	end

	gvn_store u_store (
		.clk     (clk),
		.wr      (st_wr),
		.rd      (st_rd),
		.rd_data (rd_data)
	);

	// Sequencer next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		load_rsp  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (start_qry) begin
					state_d = ST_MUL_UP;
				end
			end
			ST_MUL_UP: begin
				state_d = ST_MUL_OWN;
			end
			ST_MUL_OWN: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				if (step_q == STEP_W'((1 << STEP_W) - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_wide_q <= CELLS_WIDE_RST;
			cells_high_q <= CELLS_HIGH_RST;
		end else if (cfg_acc) begin
			case (cfg_reg_t'(cfg.index))
				REG_CELLS_WIDE: cells_wide_q <= cfg.data;
				REG_CELLS_HIGH: cells_high_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Capture the query and decide which neighbors exist
	always_ff @(posedge clk) begin
		if (start_qry) begin
			x_q    <= cmd.vertex_x;
			ymul_q <= cmd.vertex_y - COORD_W'(1);
			even_q <= ~cmd.vertex_y[0];
			xpos_q <= (cmd.vertex_x != '0);
			ypos_q <= (cmd.vertex_y != '0);
			xinw_q <= (cmd.vertex_x < cells_wide_q);
			yinh_q <= (cmd.vertex_y < cells_high_q);
		end else if (state_q == ST_MUL_UP) begin
			ymul_q <= ymul_q + COORD_W'(1);
		end
	end

	// Row bases from the shared multiplier
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL_UP) begin
			row_up_q <= prod[CELL_W-1:0];
		end
		if (state_q == ST_MUL_OWN) begin
			row_own_q <= prod[CELL_W-1:0];
		end
	end

	// Advance the read slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			take_s1 <= 1'b0;
		end else begin
			take_s1 <= (state_q == ST_READ) & take;
			if (state_q == ST_READ) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	// Accumulate the read normals, wrapping to 16 bits
	always_ff @(posedge clk) begin
		if (start_qry) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
		end else if (take_s1) begin
			acc_x_q <= acc_x_q + rd_data[3*NORM_W-1:2*NORM_W];
			acc_y_q <= acc_y_q + rd_data[2*NORM_W-1:NORM_W];
			acc_z_q <= acc_z_q + rd_data[NORM_W-1:0];
		end
	end

	// Output register: hold while stalled, drop on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_acc) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_x_q <= acc_x_q;
			rsp_y_q <= acc_y_q;
			rsp_z_q <= acc_z_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.sum_x = rsp_x_q;
	assign rsp.sum_y = rsp_y_q;
	assign rsp.sum_z = rsp_z_q;
endmodule
